>>> rtl/tiny_8bit_cpu_core_top_assert.svh
// ----------------------------------------------------------------------------
// tiny_8bit_cpu_core_top_assert.svh
// Assertion macros shared by the CPU core modules.
// Each macro expects a clock named i_clk and a reset named i_rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef TINY_8BIT_CPU_CORE_TOP_ASSERT_SVH
`define TINY_8BIT_CPU_CORE_TOP_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define TCPU_ASSERT_SAME(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |-> (cond)) else $error(msg);

// condition holds in the cycle after the trigger
`define TCPU_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |=> (cond)) else $error(msg);

`endif

>>> rtl/tcpu_pkg.sv
// ----------------------------------------------------------------------------
// tcpu_pkg
// Shared types and constants of the tiny 8-bit CPU core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcpu_pkg;

    // main memory geometry
    localparam int MEM_AW    = 8;
    localparam int MEM_DEPTH = 1 << MEM_AW;

    typedef logic [7:0]        t_byte;
    typedef logic [MEM_AW-1:0] t_addr;

    // memory port request
    typedef struct packed {
        logic  we;
        logic  re;
        t_addr addr;
        t_byte wdata;
    } t_mem_req;

    // instruction opcodes (bits 15:8 of the instruction word)
    localparam t_byte OP_ADD   = 8'd0;
    localparam t_byte OP_SUB   = 8'd1;
    localparam t_byte OP_AND   = 8'd2;
    localparam t_byte OP_OR    = 8'd3;
    localparam t_byte OP_XOR   = 8'd4;
    localparam t_byte OP_NOT   = 8'd5;
    localparam t_byte OP_SHL   = 8'd6;
    localparam t_byte OP_SHR   = 8'd7;
    localparam t_byte OP_LOAD  = 8'd8;
    localparam t_byte OP_SAVE  = 8'd9;
    localparam t_byte OP_JMP   = 8'd10;
    localparam t_byte OP_JZ    = 8'd11;
    localparam t_byte OP_JC    = 8'd12;
    localparam t_byte OP_HALT  = 8'd13;

    // input item codes
    typedef enum logic [1:0] {
        ITEM_STEP  = 2'd0,
        ITEM_WRITE = 2'd1,
        ITEM_READ  = 2'd2,
        ITEM_NOP   = 2'd3
    } t_item;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH_HI,
        S_EXEC,
        S_LOAD,
        S_READ,
        S_PUB
    } t_state;

    typedef struct packed {
        logic n;
        logic v;
        logic c;
        logic z;
    } t_flags;

    // configuration space
    localparam int     CFG_AW             = 3;
    localparam logic   CFG_SEL_STEP_LIMIT = 1'b0;
    localparam logic [15:0] STEP_LIMIT_RST = 16'd1000;

endpackage

`default_nettype wire

>>> rtl/tcpu_mem.sv
// ----------------------------------------------------------------------------
// tcpu_mem
// Single-port main memory with a registered read. Per-entry valid bits
// make entries not yet written read as zero after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "tiny_8bit_cpu_core_top_assert.svh"

module tcpu_mem (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tcpu_pkg::t_mem_req i_req,
    output tcpu_pkg::t_byte        o_rdata
);

    tcpu_pkg::t_byte                 r_mem [tcpu_pkg::MEM_DEPTH];
    logic [tcpu_pkg::MEM_DEPTH-1:0]  r_vld;
    tcpu_pkg::t_byte                 r_rdata;
    logic                            r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_vld[i_req.addr] <= 1'b1;
            end
            if (i_req.re) begin
                r_rvld <= r_vld[i_req.addr];
            end
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;

    // single port: never a read and a write in one cycle
    `TCPU_ASSERT_SAME(a_mem_one_access, i_req.we, !i_req.re, "memory read and write collide")

endmodule

`default_nettype wire

>>> rtl/tiny_8bit_cpu_core_top.sv
// ----------------------------------------------------------------------------
// tiny_8bit_cpu_core_top
// 8-bit CPU core: 256-byte main memory, four registers, PC and Z/C/V/N flags.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one item per beat:
//   step one instruction, write a memory byte, or read a memory byte.
//   Output channel (o_out_valid / i_out_stall) returns one beat per item with
//   the machine state after that item.
//   Items are handled one at a time; the memory has a single port with a
//   registered read, and each access takes its own sequencer state:
//     step   S_IDLE and S_FETCH_HI (fetch reads), S_EXEC; LOAD adds S_LOAD (data read)
//     read   S_IDLE, S_READ; write, ignored item or stopped step S_IDLE.
//   The item's result is registered in the output register. A held result
//   does not block the next item; an item that completes while the output is
//   still stalled is parked until the output frees up.
//   Reset clears registers, flags, PC and step count, sets the run flag, sets
//   step_limit to 1000 and marks all memory bytes as zero.
//   step_limit sits at byte address 0 of the APB port; write it only while
//   no item is outstanding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "tiny_8bit_cpu_core_top_assert.svh"

module tiny_8bit_cpu_core_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // input channel
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [1:0]                  i_opcode,
    input  wire logic [7:0]                  i_mem_addr,
    input  wire logic [7:0]                  i_mem_data,
    // output channel
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [7:0]                       o_pc_now,
    output logic [7:0]                       o_reg0,
    output logic [7:0]                       o_reg1,
    output logic [7:0]                       o_reg2,
    output logic [7:0]                       o_reg3,
    output logic                             o_flag_zero,
    output logic                             o_flag_carry,
    output logic                             o_flag_overflow,
    output logic                             o_flag_negative,
    output logic                             o_is_running,
    output logic [7:0]                       o_read_data,
    output logic                             o_bad_instruction,
    // configuration port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [tcpu_pkg::CFG_AW-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    tcpu_pkg::t_state   r_state, n_state;
    tcpu_pkg::t_byte    r_pc, n_pc;
    tcpu_pkg::t_byte    r_regs [4];
    tcpu_pkg::t_byte    n_regs [4];
    tcpu_pkg::t_flags   r_flags, n_flags;
    logic               r_run, n_run;
    logic [15:0]        r_step_cnt, n_step_cnt;
    logic [15:0]        r_step_limit;
    tcpu_pkg::t_byte    r_ir_lo, n_ir_lo;
    tcpu_pkg::t_byte    r_res_rd, n_res_rd;
    logic               r_res_bad, n_res_bad;

    tcpu_pkg::t_mem_req mem_req;
    tcpu_pkg::t_byte    mem_q;

    logic               active;
    logic               fin_ok;
    logic               commit;
    logic               publish;
    tcpu_pkg::t_byte    res_rd;
    logic               res_bad;

    // execute datapath
    tcpu_pkg::t_byte    ex_op;
    logic [1:0]         ex_ra;
    logic [1:0]         ex_rb;
    tcpu_pkg::t_byte    ex_a;
    tcpu_pkg::t_byte    ex_b;
    tcpu_pkg::t_byte    ex_b_in;
    logic [8:0]         ex_sum;
    tcpu_pkg::t_byte    alu_r;
    logic               alu_c;
    logic               alu_v;
    logic               alu_wr;

    logic               cfg_wr;

    tcpu_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rdata (mem_q)
    );

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == tcpu_pkg::CFG_SEL_STEP_LIMIT);
    assign prdata = (paddr[2] == tcpu_pkg::CFG_SEL_STEP_LIMIT) ? {16'd0, r_step_limit} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_limit <= tcpu_pkg::STEP_LIMIT_RST;
        end else if (cfg_wr) begin
            r_step_limit <= pwdata[15:0];
        end
    end

    // ------------------------------------------------------------------
    // ALU, operands from the fetched word: high byte straight off memory
    // ------------------------------------------------------------------
    assign ex_op   = mem_q;
    assign ex_ra   = r_ir_lo[7:6];
    assign ex_rb   = r_ir_lo[5:4];
    assign ex_a    = r_regs[ex_ra];
    assign ex_b    = r_regs[ex_rb];
    assign ex_b_in = (ex_op == tcpu_pkg::OP_SUB) ? ~ex_b : ex_b;
    assign ex_sum  = {1'b0, ex_a} + {1'b0, ex_b_in}
                   + {8'd0, (ex_op == tcpu_pkg::OP_SUB)};

    always_comb begin
        alu_r  = '0;
        alu_c  = 1'b0;
        alu_v  = 1'b0;
        alu_wr = 1'b1;
        case (ex_op) inside
            tcpu_pkg::OP_ADD, tcpu_pkg::OP_SUB: begin
                alu_r = ex_sum[7:0];
                alu_c = ex_sum[8];
                alu_v = (ex_a[7] == ex_b_in[7]) && (ex_sum[7] != ex_a[7]);
            end
            tcpu_pkg::OP_AND: alu_r = ex_a & ex_b;
            tcpu_pkg::OP_OR:  alu_r = ex_a | ex_b;
            tcpu_pkg::OP_XOR: alu_r = ex_a ^ ex_b;
            tcpu_pkg::OP_NOT: alu_r = ~ex_a;
            tcpu_pkg::OP_SHL: begin
                alu_r = {ex_a[6:0], 1'b0};
                alu_c = ex_a[7];
            end
            tcpu_pkg::OP_SHR: begin
                alu_r = {1'b0, ex_a[7:1]};
                alu_c = ex_a[0];
            end
            default: alu_wr = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    assign active     = r_run && (r_step_cnt < r_step_limit);
    assign fin_ok     = !o_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != tcpu_pkg::S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_pc       = r_pc;
        n_regs     = r_regs;
        n_flags    = r_flags;
        n_run      = r_run;
        n_step_cnt = r_step_cnt;
        n_ir_lo    = r_ir_lo;
        n_res_rd   = r_res_rd;
        n_res_bad  = r_res_bad;
        mem_req    = '0;
        commit     = 1'b0;
        publish    = 1'b0;
        res_rd     = '0;
        res_bad    = 1'b0;

        unique case (r_state)
            tcpu_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    unique case (tcpu_pkg::t_item'(i_opcode))
                        tcpu_pkg::ITEM_STEP: begin
                            if (active) begin
                                mem_req.re   = 1'b1;
                                mem_req.addr = r_pc[tcpu_pkg::MEM_AW-1:0];
                                n_state      = tcpu_pkg::S_FETCH_HI;
                            end else begin
                                commit = 1'b1;
                            end
                        end
                        tcpu_pkg::ITEM_WRITE: begin
                            mem_req.we    = 1'b1;
                            mem_req.addr  = i_mem_addr[tcpu_pkg::MEM_AW-1:0];
                            mem_req.wdata = i_mem_data;
                            commit        = 1'b1;
                        end
                        tcpu_pkg::ITEM_READ: begin
                            mem_req.re   = 1'b1;
                            mem_req.addr = i_mem_addr[tcpu_pkg::MEM_AW-1:0];
                            n_state      = tcpu_pkg::S_READ;
                        end
                        default: commit = 1'b1;
                    endcase
                end
            end
            tcpu_pkg::S_FETCH_HI: begin
                n_ir_lo      = mem_q;
                mem_req.re   = 1'b1;
                mem_req.addr = tcpu_pkg::MEM_AW'(r_pc + 8'd1);
                n_state      = tcpu_pkg::S_EXEC;
            end
            tcpu_pkg::S_EXEC: begin
                n_pc       = r_pc + 8'd2;
                n_step_cnt = r_step_cnt + 16'd1;
                commit     = 1'b1;
                if (alu_wr) begin
                    n_regs[ex_ra] = alu_r;
                    n_flags.z     = (alu_r == 8'd0);
                    n_flags.n     = alu_r[7];
                    n_flags.c     = alu_c;
                    n_flags.v     = alu_v;
                end else begin
                    unique case (ex_op)
                        tcpu_pkg::OP_LOAD: begin
                            mem_req.re   = 1'b1;
                            mem_req.addr = r_ir_lo[tcpu_pkg::MEM_AW-1:0];
                            commit       = 1'b0;
                            n_state      = tcpu_pkg::S_LOAD;
                        end
                        tcpu_pkg::OP_SAVE: begin
                            mem_req.we    = 1'b1;
                            mem_req.addr  = r_ir_lo[tcpu_pkg::MEM_AW-1:0];
                            mem_req.wdata = ex_a;
                        end
                        tcpu_pkg::OP_JMP: n_pc = r_ir_lo;
                        tcpu_pkg::OP_JZ: begin
                            if (r_flags.z) begin
                                n_pc = r_ir_lo;
                            end
                        end
                        tcpu_pkg::OP_JC: begin
                            if (r_flags.c) begin
                                n_pc = r_ir_lo;
                            end
                        end
                        tcpu_pkg::OP_HALT: n_run = 1'b0;
                        default: res_bad = 1'b1;
                    endcase
                end
            end
            tcpu_pkg::S_LOAD: begin
                n_regs[ex_ra] = mem_q;
                commit        = 1'b1;
            end
            tcpu_pkg::S_READ: begin
                res_rd = mem_q;
                commit = 1'b1;
            end
            tcpu_pkg::S_PUB: begin
                // state already committed, result waits for the output register
                res_rd  = r_res_rd;
                res_bad = r_res_bad;
                if (fin_ok) begin
                    publish = 1'b1;
                    n_state = tcpu_pkg::S_IDLE;
                end
            end
            default: n_state = tcpu_pkg::S_IDLE;
        endcase

        if (commit) begin
            n_res_rd  = res_rd;
            n_res_bad = res_bad;
            if (fin_ok) begin
                publish = 1'b1;
                n_state = tcpu_pkg::S_IDLE;
            end else begin
                n_state = tcpu_pkg::S_PUB;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= tcpu_pkg::S_IDLE;
            r_pc       <= '0;
            r_regs     <= '{default: '0};
            r_flags    <= '0;
            r_run      <= 1'b1;
            r_step_cnt <= '0;
        end else begin
            r_state    <= n_state;
            r_pc       <= n_pc;
            r_regs     <= n_regs;
            r_flags    <= n_flags;
            r_run      <= n_run;
            r_step_cnt <= n_step_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ir_lo   <= n_ir_lo;
        r_res_rd  <= n_res_rd;
        r_res_bad <= n_res_bad;
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (publish) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (publish) begin
            o_pc_now          <= n_pc;
            o_reg0            <= n_regs[0];
            o_reg1            <= n_regs[1];
            o_reg2            <= n_regs[2];
            o_reg3            <= n_regs[3];
            o_flag_zero       <= n_flags.z;
            o_flag_carry      <= n_flags.c;
            o_flag_overflow   <= n_flags.v;
            o_flag_negative   <= n_flags.n;
            o_is_running      <= n_run && (n_step_cnt < r_step_limit);
            o_read_data       <= res_rd;
            o_bad_instruction <= res_bad;
        end
    end

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `TCPU_ASSERT_NEXT(a_exec_counts_step, r_state == tcpu_pkg::S_EXEC, r_step_cnt == $past(r_step_cnt) + 16'd1, "executed step did not advance step count")
    `TCPU_ASSERT_SAME(a_pub_blocked_only_by_stall, r_state == tcpu_pkg::S_PUB, o_out_valid, "parked result with free output")
    `TCPU_ASSERT_SAME(a_mem_write_phase, mem_req.we, r_state == tcpu_pkg::S_IDLE || r_state == tcpu_pkg::S_EXEC, "memory write outside idle or execute")

endmodule

`default_nettype wire
